// ===== design/sd_card_init_sequencer_top_defines.svh =====
// Assertion macros for the SD card init sequencer.
// Used by sd_card_init_sequencer_top; expects clk and rst_n in scope.
`ifndef SD_CARD_INIT_SEQUENCER_TOP_DEFINES_SVH
`define SD_CARD_INIT_SEQUENCER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property outside reset
`define SDI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property that also covers the reset cycles
`define SDI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDI_ASSERT(lbl, prop, msg)
`define SDI_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== design/sdi_pkg.sv =====
// Shared types, codes and helpers of the SD card init sequencer.
// No dependencies; used by the interfaces, sdi_seq and the top level.
package sdi_pkg;

  // Field widths
  localparam int IdxW   = 6;
  localparam int ArgW   = 32;
  localparam int KindW  = 2;
  localparam int CodeW  = 4;
  localparam int OutcW  = 2;
  localparam int RespW  = 32;
  localparam int LimitW = 16;
  localparam int RcaW   = 16;

  // Configuration port
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam logic CfgIdxLimit = 1'b0;  // word index of ready_retry_limit
  localparam logic [LimitW-1:0] RetryLimitReset = 16'd1000;

  // Input item codes
  localparam logic CmdStart  = 1'b0;
  localparam logic CmdReport = 1'b1;
  localparam logic [OutcW-1:0] OutcomeDone = 2'd0;

  // Response kinds
  localparam logic [KindW-1:0] RespNone  = 2'd0;
  localparam logic [KindW-1:0] RespShort = 2'd1;
  localparam logic [KindW-1:0] RespLong  = 2'd2;

  // Command indexes and arguments
  localparam logic [IdxW-1:0] IdxGoIdle   = 6'd0;
  localparam logic [IdxW-1:0] IdxSendIf   = 6'd8;
  localparam logic [IdxW-1:0] IdxAppCmd   = 6'd55;
  localparam logic [IdxW-1:0] IdxOpCond   = 6'd41;
  localparam logic [IdxW-1:0] IdxAllCid   = 6'd2;
  localparam logic [IdxW-1:0] IdxRelAddr  = 6'd3;
  localparam logic [IdxW-1:0] IdxSelect   = 6'd7;
  localparam logic [IdxW-1:0] IdxBusWidth = 6'd6;
  localparam logic [ArgW-1:0] ArgSendIf   = 32'h0000_01AA;
  localparam logic [ArgW-1:0] ArgOpCond   = 32'h40FF_8000;
  localparam logic [ArgW-1:0] ArgBus4     = 32'h0000_0002;
  localparam logic [7:0]      EchoPattern = 8'hAA;
  localparam int              BusyBit     = 31;

  // Result codes
  localparam logic [CodeW-1:0] ResOk          = 4'd0;
  localparam logic [CodeW-1:0] ResCmd0Fail    = 4'd1;
  localparam logic [CodeW-1:0] ResCmd8Fail    = 4'd2;
  localparam logic [CodeW-1:0] ResEchoBad     = 4'd3;
  localparam logic [CodeW-1:0] ResPoll55Fail  = 4'd4;
  localparam logic [CodeW-1:0] ResAcmd41Fail  = 4'd5;
  localparam logic [CodeW-1:0] ResNotReady    = 4'd6;
  localparam logic [CodeW-1:0] ResCmd2Fail    = 4'd7;
  localparam logic [CodeW-1:0] ResCmd3Fail    = 4'd8;
  localparam logic [CodeW-1:0] ResCmd7Fail    = 4'd9;
  localparam logic [CodeW-1:0] ResBus55Fail   = 4'd10;
  localparam logic [CodeW-1:0] ResAcmd6Fail   = 4'd11;

  typedef struct packed {
    logic             command;
    logic [OutcW-1:0] outcome;
    logic [RespW-1:0] response_word;
  } in_item_t;

  typedef struct packed {
    logic             issue;
    logic [IdxW-1:0]  cmd_index;
    logic [ArgW-1:0]  cmd_argument;
    logic [KindW-1:0] response_kind;
    logic [CodeW-1:0] result_code;
    logic             wide_bus;
  } out_item_t;

  // Build a command item
  function automatic out_item_t mk_cmd(logic [IdxW-1:0] idx, logic [ArgW-1:0] arg,
                                       logic [KindW-1:0] kind);
    out_item_t r;
    r.issue         = 1'b1;
    r.cmd_index     = idx;
    r.cmd_argument  = arg;
    r.response_kind = kind;
    r.result_code   = ResOk;
    r.wide_bus      = 1'b0;
    return r;
  endfunction

  // Build a finish item
  function automatic out_item_t mk_finish(logic [CodeW-1:0] code);
    out_item_t r;
    r.issue         = 1'b0;
    r.cmd_index     = '0;
    r.cmd_argument  = '0;
    r.response_kind = RespNone;
    r.result_code   = code;
    r.wide_bus      = (code == ResOk);
    return r;
  endfunction

endpackage

// ===== design/sdi_in_if.sv =====
// Input channel of the SD card init sequencer: valid/ready plus one item.
// Depends on sdi_pkg for the field widths.
interface sdi_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [sdi_pkg::OutcW-1:0]  outcome;
  logic [sdi_pkg::RespW-1:0]  response_word;

  modport source (output valid, command, outcome, response_word, input ready);
  modport sink   (input valid, command, outcome, response_word, output ready);
endinterface

// ===== design/sdi_out_if.sv =====
// Result channel of the SD card init sequencer: valid/ready plus one item.
// Depends on sdi_pkg for the field widths.
interface sdi_out_if;
  logic                       valid;
  logic                       ready;
  logic                       issue;
  logic [sdi_pkg::IdxW-1:0]   cmd_index;
  logic [sdi_pkg::ArgW-1:0]   cmd_argument;
  logic [sdi_pkg::KindW-1:0]  response_kind;
  logic [sdi_pkg::CodeW-1:0]  result_code;
  logic                       wide_bus;

  modport source (output valid, issue, cmd_index, cmd_argument, response_kind,
                  result_code, wide_bus, input ready);
  modport sink   (input valid, issue, cmd_index, cmd_argument, response_kind,
                  result_code, wide_bus, output ready);
endinterface

// ===== design/sdi_seq.sv =====
// Init step sequencer: holds step, poll count and card address, and decodes
// the next command or finish for one item. Depends on sdi_pkg.
module sdi_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  sdi_pkg::in_item_t             item,
  input  logic [sdi_pkg::LimitW-1:0]    retry_limit,
  output logic                          produce,
  output sdi_pkg::out_item_t            result
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_CMD0   = 4'd1,
    ST_CMD8   = 4'd2,
    ST_POLL55 = 4'd3,
    ST_ACMD41 = 4'd4,
    ST_CMD2   = 4'd5,
    ST_CMD3   = 4'd6,
    ST_CMD7   = 4'd7,
    ST_BUS55  = 4'd8,
    ST_ACMD6  = 4'd9
  } step_t;

  step_t                        step_r, step_nxt;
  logic [sdi_pkg::LimitW-1:0]   retries_r, retries_nxt, retries_dec;
  logic [sdi_pkg::RcaW-1:0]     rca_r, rca_nxt;
  logic [sdi_pkg::ArgW-1:0]     rca_arg;
  logic                         ok;

  // Decode the next step and result
  always_comb begin
    ok          = (item.outcome == sdi_pkg::OutcomeDone);
    rca_arg     = {rca_r, {(sdi_pkg::ArgW-sdi_pkg::RcaW){1'b0}}};
    retries_dec = retries_r - 1'b1;
    step_nxt    = step_r;
    retries_nxt = retries_r;
    rca_nxt     = rca_r;
    produce     = 1'b1;
    result      = sdi_pkg::mk_finish(sdi_pkg::ResOk);
    if (item.command == sdi_pkg::CmdStart) begin
      result   = sdi_pkg::mk_cmd(sdi_pkg::IdxGoIdle, '0, sdi_pkg::RespNone);
      step_nxt = ST_CMD0;
    end else begin
      case (step_r)
        ST_CMD0: begin
          if (!ok) begin
            result   = sdi_pkg::mk_finish(sdi_pkg::ResCmd0Fail);
            step_nxt = ST_IDLE;
          end else begin
            result   = sdi_pkg::mk_cmd(sdi_pkg::IdxSendIf, sdi_pkg::ArgSendIf,
                                       sdi_pkg::RespShort);
            step_nxt = ST_CMD8;
          end
        end
        ST_CMD8: begin
          if (!ok) begin
            result   = sdi_pkg::mk_finish(sdi_pkg::ResCmd8Fail);
            step_nxt = ST_IDLE;
          end else if (item.response_word[7:0] != sdi_pkg::EchoPattern) begin
            result   = sdi_pkg::mk_finish(sdi_pkg::ResEchoBad);
            step_nxt = ST_IDLE;
          end else begin
            retries_nxt = retry_limit;
            result      = sdi_pkg::mk_cmd(sdi_pkg::IdxAppCmd, '0, sdi_pkg::RespShort);
            step_nxt    = ST_POLL55;
          end
        end
        ST_POLL55: begin
          if (!ok) begin
            result   = sdi_pkg::mk_finish(sdi_pkg::ResPoll55Fail);
            step_nxt = ST_IDLE;
          end else begin
            result   = sdi_pkg::mk_cmd(sdi_pkg::IdxOpCond, sdi_pkg::ArgOpCond,
                                       sdi_pkg::RespShort);
            step_nxt = ST_ACMD41;
          end
        end
        ST_ACMD41: begin
          if (!ok) begin
            result   = sdi_pkg::mk_finish(sdi_pkg::ResAcmd41Fail);
            step_nxt = ST_IDLE;
          end else begin
            // Count the poll; running out wins over a ready card
            retries_nxt = retries_dec;
            if (retries_dec == '0) begin
              result   = sdi_pkg::mk_finish(sdi_pkg::ResNotReady);
              step_nxt = ST_IDLE;
            end else if (!item.response_word[sdi_pkg::BusyBit]) begin
              result   = sdi_pkg::mk_cmd(sdi_pkg::IdxAppCmd, '0, sdi_pkg::RespShort);
              step_nxt = ST_POLL55;
            end else begin
              result   = sdi_pkg::mk_cmd(sdi_pkg::IdxAllCid, '0, sdi_pkg::RespLong);
              step_nxt = ST_CMD2;
            end
          end
        end
        ST_CMD2: begin
          if (!ok) begin
            result   = sdi_pkg::mk_finish(sdi_pkg::ResCmd2Fail);
            step_nxt = ST_IDLE;
          end else begin
            result   = sdi_pkg::mk_cmd(sdi_pkg::IdxRelAddr, '0, sdi_pkg::RespShort);
            step_nxt = ST_CMD3;
          end
        end
        ST_CMD3: begin
          if (!ok) begin
            result   = sdi_pkg::mk_finish(sdi_pkg::ResCmd3Fail);
            step_nxt = ST_IDLE;
          end else begin
            // Capture the relative card address from the upper half
            rca_nxt  = item.response_word[sdi_pkg::RespW-1 -: sdi_pkg::RcaW];
            result   = sdi_pkg::mk_cmd(sdi_pkg::IdxSelect,
                         {rca_nxt, {(sdi_pkg::ArgW-sdi_pkg::RcaW){1'b0}}},
                         sdi_pkg::RespShort);
            step_nxt = ST_CMD7;
          end
        end
        ST_CMD7: begin
          if (!ok) begin
            result   = sdi_pkg::mk_finish(sdi_pkg::ResCmd7Fail);
            step_nxt = ST_IDLE;
          end else begin
            result   = sdi_pkg::mk_cmd(sdi_pkg::IdxAppCmd, rca_arg, sdi_pkg::RespShort);
            step_nxt = ST_BUS55;
          end
        end
        ST_BUS55: begin
          if (!ok) begin
            result   = sdi_pkg::mk_finish(sdi_pkg::ResBus55Fail);
            step_nxt = ST_IDLE;
          end else begin
            result   = sdi_pkg::mk_cmd(sdi_pkg::IdxBusWidth, sdi_pkg::ArgBus4,
                                       sdi_pkg::RespShort);
            step_nxt = ST_ACMD6;
          end
        end
        ST_ACMD6: begin
          result   = sdi_pkg::mk_finish(ok ? sdi_pkg::ResOk : sdi_pkg::ResAcmd6Fail);
          step_nxt = ST_IDLE;
        end
        default: begin
          // Idle or unused code: drop the report
          produce  = 1'b0;
          step_nxt = ST_IDLE;
        end
      endcase
    end
  end

  // Hold sequence state; advance when an item is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= ST_IDLE;
      retries_r <= '0;
      rca_r     <= '0;
    end else if (advance) begin
      step_r    <= step_nxt;
      retries_r <= retries_nxt;
      rca_r     <= rca_nxt;
    end
  end

endmodule

// ===== design/sd_card_init_sequencer_top.sv =====
// SD card power-up sequencer: top level.
// Channels: in_if (sink) takes start/report items, out_if (source) gives
//   the next command to issue or a finish with a result code.
// Configuration: APB-style port; ready_retry_limit lies at byte address 0,
//   writes take effect in the access phase, pready is always high.
// An accepted item sits in the input register and its result, if any, is
//   loaded into the output register when the item advances, which needs
//   the output register to be free or draining.
// Throughput: one item per cycle while the receiver does not stall; the
//   step decode between the two registers is a single small state transition.
// A stalled receiver holds the output register; one more item is held in
//   the input register, after which in_if.ready drops until out_if.ready.
// Reset (rst_n low, synchronous) empties both registers, returns the
//   sequencer to idle and loads ready_retry_limit with 1000.
// A report item while idle gives no result.
// Depends on sdi_pkg, sdi_in_if, sdi_out_if, sdi_seq and the defines header.
`include "sd_card_init_sequencer_top_defines.svh"

module sd_card_init_sequencer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  sdi_in_if.sink                         in_if,
  sdi_out_if.source                      out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sdi_pkg::CfgAddrW-1:0]   paddr,
  input  logic [sdi_pkg::CfgDataW-1:0]   pwdata,
  output logic [sdi_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready
);

  logic                        in_v_r;
  sdi_pkg::in_item_t           in_item_r, in_item_nxt;
  logic                        out_v_r;
  sdi_pkg::out_item_t          out_item_r, seq_result;
  logic                        seq_produce;
  logic                        advance;
  logic                        cfg_wr;
  logic [sdi_pkg::LimitW-1:0]  limit_r;

  // Move the held item on when the output register is free or draining
  assign advance     = in_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready = !in_v_r || advance;

  assign in_item_nxt.command       = in_if.command;
  assign in_item_nxt.outcome       = in_if.outcome;
  assign in_item_nxt.response_word = in_if.response_word;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      limit_r <= sdi_pkg::RetryLimitReset;
    end else begin
      if (in_if.valid && in_if.ready) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= seq_produce;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_wr && paddr[sdi_pkg::CfgAddrW-1] == sdi_pkg::CfgIdxLimit) begin
        limit_r <= pwdata[sdi_pkg::LimitW-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_item_r <= in_item_nxt;
    end
    if (advance && seq_produce) begin
      out_item_r <= seq_result;
    end
  end

  sdi_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .item        (in_item_r),
    .retry_limit (limit_r),
    .produce     (seq_produce),
    .result      (seq_result)
  );

  // Result channel
  assign out_if.valid         = out_v_r;
  assign out_if.issue         = out_item_r.issue;
  assign out_if.cmd_index     = out_item_r.cmd_index;
  assign out_if.cmd_argument  = out_item_r.cmd_argument;
  assign out_if.response_kind = out_item_r.response_kind;
  assign out_if.result_code   = out_item_r.result_code;
  assign out_if.wide_bus      = out_item_r.wide_bus;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[sdi_pkg::CfgAddrW-1] == sdi_pkg::CfgIdxLimit) ?
                  {{(sdi_pkg::CfgDataW-sdi_pkg::LimitW){1'b0}}, limit_r} : '0;

  // Checks
  `SDI_ASSERT_RST(a_reset_empty, !rst_n |=> !in_v_r && !out_v_r,
                  "pipeline not empty after reset")
  `SDI_ASSERT(a_stall_only_full, !in_if.ready |-> in_v_r && out_v_r && !out_if.ready,
              "input stalled while a register is free")
  `SDI_ASSERT(a_wide_on_success,
              out_v_r && out_item_r.wide_bus |->
                !out_item_r.issue && out_item_r.result_code == sdi_pkg::ResOk,
              "wide bus outside a successful finish")
  `SDI_ASSERT(a_limit_write,
              cfg_wr && paddr[sdi_pkg::CfgAddrW-1] == sdi_pkg::CfgIdxLimit |=>
                limit_r == $past(pwdata[sdi_pkg::LimitW-1:0]),
              "retry limit write lost")

endmodule

// ===== tb/sdi_seq_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the SD card init sequencer: tracks the bring-up steps and
// compares each result item with the command or finish it predicts.
// Depends on sdi_pkg, sdi_in_if and sdi_out_if.
module sdi_seq_checker
  import sdi_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  sdi_in_if                   in_ch,
  sdi_out_if                  out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  input  logic [CfgDataW-1:0] prdata,
  output int                  mismatches,
  output int                  cmds_pending,
  output int                  results_checked,
  output int                  bringups
);

  localparam logic [CfgAddrW-1:0] LimitAddr = CfgAddrW'({CfgIdxLimit, 2'b00});

  typedef enum logic [3:0] {
    StIdle, StGoIdle, StIfCond, StPollApp, StPollOp,
    StAllCid, StRelAddr, StSelect, StBusApp, StBusWidth
  } init_step_t;

  init_step_t       at_step;
  logic [LimitW-1:0] retry_limit;
  logic [LimitW-1:0] polls_left;
  logic [RcaW-1:0]   rca;
  out_item_t         cmds_due[$];

  // Issue a command and move to the step that waits for its outcome
  function automatic out_item_t go(logic [IdxW-1:0] idx, logic [ArgW-1:0] arg,
                                   logic [KindW-1:0] kind, init_step_t nxt);
    out_item_t r;
    r               = '0;
    r.issue         = 1'b1;
    r.cmd_index     = idx;
    r.cmd_argument  = arg;
    r.response_kind = kind;
    at_step         = nxt;
    return r;
  endfunction

  // End the sequence with a result code
  function automatic out_item_t done(logic [CodeW-1:0] code);
    out_item_t r;
    r             = '0;
    r.result_code = code;
    r.wide_bus    = (code == ResOk);
    at_step       = StIdle;
    return r;
  endfunction

  // Work out the item the block answers with; 0 when it gives none
  function automatic bit next_command(in_item_t it, output out_item_t cmd);
    bit ok;
    logic [ArgW-1:0] rca_arg;
    ok      = (it.outcome == OutcomeDone);
    rca_arg = {rca, 16'h0000};
    cmd     = '0;
    if (it.command == CmdStart) begin
      cmd = go(IdxGoIdle, '0, RespNone, StGoIdle);
      return 1'b1;
    end
    case (at_step)
      StGoIdle: cmd = ok ? go(IdxSendIf, ArgSendIf, RespShort, StIfCond) : done(ResCmd0Fail);
      StIfCond: begin
        if (!ok) begin
          cmd = done(ResCmd8Fail);
        end else if (it.response_word[7:0] != EchoPattern) begin
          cmd = done(ResEchoBad);
        end else begin
          polls_left = retry_limit;
          cmd = go(IdxAppCmd, '0, RespShort, StPollApp);
        end
      end
      StPollApp: cmd = ok ? go(IdxOpCond, ArgOpCond, RespShort, StPollOp) : done(ResPoll55Fail);
      StPollOp: begin
        if (!ok) begin
          cmd = done(ResAcmd41Fail);
        end else begin
          // a limit of zero wraps here and allows a full 65536 polls
          polls_left = polls_left - 1'b1;
          if (polls_left == '0) cmd = done(ResNotReady);
          else if (!it.response_word[BusyBit]) cmd = go(IdxAppCmd, '0, RespShort, StPollApp);
          else cmd = go(IdxAllCid, '0, RespLong, StAllCid);
        end
      end
      StAllCid: cmd = ok ? go(IdxRelAddr, '0, RespShort, StRelAddr) : done(ResCmd2Fail);
      StRelAddr: begin
        if (!ok) begin
          cmd = done(ResCmd3Fail);
        end else begin
          rca = it.response_word[31:16];
          cmd = go(IdxSelect, {it.response_word[31:16], 16'h0000}, RespShort, StSelect);
        end
      end
      StSelect:   cmd = ok ? go(IdxAppCmd, rca_arg, RespShort, StBusApp) : done(ResCmd7Fail);
      StBusApp:   cmd = ok ? go(IdxBusWidth, ArgBus4, RespShort, StBusWidth) : done(ResBus55Fail);
      StBusWidth: cmd = done(ok ? ResOk : ResAcmd6Fail);
      default: begin
        at_step = StIdle;
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // Follow the config port and both channels at each edge
  always @(posedge clk) begin : track
    out_item_t want;
    out_item_t cmd;
    if (!rst_n) begin
      at_step         = StIdle;
      retry_limit     = RetryLimitReset;
      polls_left      = '0;
      rca             = '0;
      cmds_due.delete();
      mismatches      = 0;
      cmds_pending    = 0;
      results_checked = 0;
      bringups        = 0;
    end else begin
      if (psel && penable && pready && pwrite && paddr == LimitAddr)
        retry_limit = pwdata[LimitW-1:0];
      if (psel && penable && pready && !pwrite && paddr == LimitAddr)
        check_field("retry limit readback", 32'(retry_limit), 32'(prdata[LimitW-1:0]));
      if (out_ch.valid && out_ch.ready) begin
        if (cmds_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, issue %0b index %0d code %0d", $time,
                   out_ch.issue, out_ch.cmd_index, out_ch.result_code);
        end else begin
          want = cmds_due.pop_front();
          check_field("issue", 32'(want.issue), 32'(out_ch.issue));
          check_field("cmd_index", 32'(want.cmd_index), 32'(out_ch.cmd_index));
          check_field("cmd_argument", want.cmd_argument, out_ch.cmd_argument);
          check_field("response_kind", 32'(want.response_kind), 32'(out_ch.response_kind));
          check_field("result_code", 32'(want.result_code), 32'(out_ch.result_code));
          check_field("wide_bus", 32'(want.wide_bus), 32'(out_ch.wide_bus));
          results_checked++;
          if (!want.issue && want.result_code == ResOk) bringups++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (next_command({in_ch.command, in_ch.outcome, in_ch.response_word}, cmd))
          cmds_due.push_back(cmd);
      end
      cmds_pending = cmds_due.size();
    end
  end

endmodule

// ===== tb/tb_sd_card_init_sequencer_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the SD card init sequencer: drives bring-up sequences,
// retry-limit writes and random stalls. Depends on sdi_pkg, the two channel
// interfaces, sdi_seq_checker and the block itself.
module tb_sd_card_init_sequencer_top;
  import sdi_pkg::*;

  localparam logic [OutcW-1:0]    OutcPollTimeout = 2'd1;
  localparam logic [OutcW-1:0]    OutcCardFail    = 2'd2;
  localparam logic [OutcW-1:0]    OutcUnknown     = 2'd3;
  localparam logic [CfgAddrW-1:0] LimitAddr       = CfgAddrW'({CfgIdxLimit, 2'b00});
  localparam int                  PhaseItems      = 240;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  bit                  steady;
  int                  items_sent;
  int                  settings_run;
  logic [LimitW-1:0]   cur_limit;
  int                  mismatches;
  int                  cmds_pending;
  int                  results_checked;
  int                  bringups;

  sdi_in_if  in_ch ();
  sdi_out_if out_ch ();

  sd_card_init_sequencer_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sdi_seq_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .mismatches      (mismatches),
    .cmds_pending    (cmds_pending),
    .results_checked (results_checked),
    .bringups        (bringups)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the result side about 15% of the time, never in a steady phase
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= rst_n && (steady || $urandom_range(0, 99) >= 15);
    end
  end

  initial begin
    #20ms;
    $display("sd_card_init_sequencer_top test failed");
    $finish;
  end

  // Offer one item after an optional gap and hold it until taken
  task automatic put(logic command, logic [OutcW-1:0] outc, logic [RespW-1:0] resp);
    while (!steady && $urandom_range(0, 99) < 15) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= command;
    in_ch.outcome       <= outc;
    in_ch.response_word <= resp;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic report(bit fail, logic [RespW-1:0] resp);
    put(CmdReport, fail ? OutcW'($urandom_range(OutcPollTimeout, OutcUnknown)) : OutcomeDone,
        resp);
  endtask

  // Drain all expected results, then let any silent item clear the pipe
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (cmds_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_access(bit wr, logic [CfgDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= LimitAddr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limit(logic [LimitW-1:0] lim);
    settle();
    cfg_access(1'b1, CfgDataW'(lim));
    cfg_access(1'b0, '0);
    cur_limit = lim;
    settings_run++;
  endtask

  // One bring-up with random content; may fail, exhaust the polls or be cut short
  task automatic run_init_sequence();
    int fail_at;
    int cut_at;
    int polls;
    logic [RespW-1:0] w;
    fail_at = $urandom_range(0, 17);
    cut_at  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 10;
    polls   = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
    put(CmdStart, OutcW'($urandom), $urandom);
    report(fail_at == 0, $urandom);
    if (fail_at == 0 || cut_at == 1) return;
    // echo byte right unless a mismatch is wanted
    w = $urandom;
    w[7:0] = (fail_at == 2) ? (EchoPattern ^ 8'($urandom_range(1, 255))) : EchoPattern;
    report(fail_at == 1, w);
    if (fail_at == 1 || fail_at == 2 || cut_at == 2) return;
    // poll loop: the card reports ready on the last poll
    for (int p = 1; p <= polls; p++) begin
      report(fail_at == 3 && p == polls, $urandom);
      if (fail_at == 3 && p == polls) return;
      w = $urandom;
      w[BusyBit] = (p == polls);
      report(fail_at == 4 && p == polls, w);
      if ((fail_at == 4 && p == polls) || (cur_limit != '0 && p == cur_limit)) return;
    end
    // identification, address, select and bus switch
    for (int s = 5; s <= 9; s++) begin
      if (cut_at == s - 2) return;
      report(fail_at == s, $urandom);
      if (fail_at == s) return;
    end
  endtask

  task automatic run_phase(int target);
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) put(1'($urandom_range(0, 1)), OutcW'($urandom), $urandom);
      end else begin
        run_init_sequence();
      end
    end
  endtask

  initial begin
    logic [LimitW-1:0] limits [7];
    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CmdStart;
    in_ch.outcome       <= OutcomeDone;
    in_ch.response_word <= '0;
    steady       = 1'b0;
    items_sent   = 0;
    settings_run = 1;
    cur_limit    = RetryLimitReset;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_access(1'b0, '0);

    // report with nothing running, then a full bring-up with one busy poll
    put(CmdReport, OutcomeDone, 32'hFFFF_FFFF);
    put(CmdStart, OutcomeDone, '0);
    put(CmdReport, OutcomeDone, '0);
    put(CmdReport, OutcomeDone, 32'hFFFF_FFAA);
    put(CmdReport, OutcomeDone, '0);
    put(CmdReport, OutcomeDone, 32'h7FFF_FFFF);
    put(CmdReport, OutcomeDone, '0);
    put(CmdReport, OutcomeDone, 32'h8000_0000);
    put(CmdReport, OutcomeDone, '0);
    put(CmdReport, OutcomeDone, 32'hFFFF_0000);
    put(CmdReport, OutcomeDone, '0);
    put(CmdReport, OutcomeDone, '0);
    put(CmdReport, OutcomeDone, '0);
    // unknown outcome counts as a failure
    put(CmdStart, OutcUnknown, 32'hFFFF_FFFF);
    put(CmdReport, OutcUnknown, '0);
    // echo byte off by one bit
    put(CmdStart, OutcomeDone, '0);
    put(CmdReport, OutcomeDone, '0);
    put(CmdReport, OutcomeDone, 32'h0000_01AB);
    // restart while running, then timeout and card failures
    put(CmdStart, OutcomeDone, '0);
    put(CmdStart, OutcCardFail, '0);
    put(CmdReport, OutcPollTimeout, '0);
    put(CmdStart, OutcomeDone, '0);
    put(CmdReport, OutcomeDone, '0);
    put(CmdReport, OutcCardFail, 32'h0000_00AA);
    put(CmdReport, OutcomeDone, '0);
    run_phase(PhaseItems);

    // sweep the retry limit: extremes, zero (wraps), a few small and two random ones
    limits = '{16'd1, 16'd2, 16'd0, 16'hFFFF, 16'd3,
               LimitW'($urandom_range(1, 65535)), LimitW'($urandom_range(4, 10))};
    foreach (limits[k]) begin
      set_limit(limits[k]);
      steady = (limits[k] == 16'hFFFF);
      run_phase(items_sent + PhaseItems);
      steady = 1'b0;
    end
    settle();
    repeat (8) @(posedge clk);

    $display("Covered %0d items over %0d retry-limit settings, zero and both extremes included.",
             items_sent, settings_run);
    $display("Checked %0d results, %0d of them full bring-ups to the 4-bit bus.",
             results_checked, bringups);
    if (mismatches == 0 && cmds_pending == 0) begin
      $display("sd_card_init_sequencer_top test passed");
    end else begin
      $display("sd_card_init_sequencer_top test failed");
    end
    $finish;
  end

endmodule
